// File: rtl/core/tnh_pkg.sv
// tnh_pkg: widths, codes, controller states and the command/status bundles
// shared by the tree next-hop controller, datapath and checker.
// No dependencies.
package tnh_pkg;

  localparam int NODE_W      = 10;
  localparam int DEPTH_W     = 10;
  localparam int MAX_NODES   = 1 << NODE_W;
  localparam int LIFT_LEVELS = 10;
  localparam int LEVEL_W     = $clog2(LIFT_LEVELS);

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [DEPTH_W-1:0]     depth_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [LIFT_LEVELS-1:0] step_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_B_RD1,
    ST_B_RD2,
    ST_B_WR,
    ST_Q_DS,
    ST_Q_DD,
    ST_Q_SETUP,
    ST_LIFT_CHK,
    ST_LIFT_WT,
    ST_CMP,
    ST_J_RU,
    ST_J_RV,
    ST_J_CMP,
    ST_PAR_RD,
    ST_PAR_WT,
    ST_DECIDE,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RD_NODE,
    RD_TBL,
    RD_U,
    RD_V
  } rd_sel_e;

  typedef enum logic {
    DEP_S,
    DEP_D
  } dep_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_LOAD,
    WR_BUILD
  } wr_mode_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_CAP_DS,
    DP_SETUP,
    DP_U_FROM_TBL,
    DP_L_FROM_U,
    DP_CAP_PU,
    DP_JUMP,
    DP_L_FROM_TBL,
    DP_LIFT_D,
    DP_LIFT_S,
    DP_RES_U,
    DP_RES_ZERO
  } dp_op_e;

  typedef struct packed {
    dp_op_e   op;
    wr_mode_e wr_mode;
    rd_sel_e  rd_sel;
    dep_sel_e dep_sel;
    node_t    node;
    level_t   level;
  } tnh_cmd_t;

  typedef struct packed {
    step_t step;
    node_t node_count;
    logic  u_zero;
    logic  u_eq_v;
    logic  l_eq_s;
    logic  dd_le_ds;
  } tnh_status_t;

endpackage

// File: rtl/core/tree_next_hop_binary_lifting.sv
// tree_next_hop_binary_lifting: top level of the tree next-hop unit.
// Depends on tnh_pkg, tnh_controller, tnh_datapath (and tnh_ram below it).
//
// After reset the block runs a clearing pass over the ancestor table, one node
// row (all lift levels at once) per cycle, with busy_o high; config writes are
// taken during it. A load item is written in the cycle it is accepted and leaves
// busy_o low. A build item reads, reads again and writes for each node and each
// lift level from one up, since each entry needs two dependent reads of the level
// below through the table's registered read port. A query runs two depth reads,
// a leveling lift over the set bits of the depth difference, then, unless the two
// nodes already meet, ten jump steps (two reads of the same level RAM each) and a
// parent read, and last, unless the decision gives node zero, a final lift.
// Every query gives one result: next_hop_o valid for the single cycle in which
// result_valid_o is high. The receiver cannot stall it; results must be taken
// when shown. Loads, builds and operation code 3 give no result.
module tree_next_hop_binary_lifting import tnh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] operation_i,
  input  logic [9:0] entry_node_i,
  input  logic [9:0] entry_parent_i,
  input  logic [9:0] entry_depth_i,
  input  logic [9:0] source_node_i,
  input  logic [9:0] dest_node_i,
  output logic       result_valid_o,
  output logic [9:0] next_hop_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i
);

  tnh_cmd_t    cmd;
  tnh_status_t stat;

  tnh_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .operation_i    (operation_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  tnh_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .entry_node_i   (entry_node_i),
    .entry_parent_i (entry_parent_i),
    .entry_depth_i  (entry_depth_i),
    .source_node_i  (source_node_i),
    .dest_node_i    (dest_node_i),
    .next_hop_o     (next_hop_o)
  );

endmodule

// File: rtl/core/tnh_ram.sv
// tnh_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tnh_datapath.sv
// tnh_datapath: ancestor table (one RAM per lift level), depth RAM, node_count
// register and the query working registers. Driven by tnh_controller.
// Depends on tnh_pkg and tnh_ram.
module tnh_datapath import tnh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tnh_cmd_t    cmd_i,
  output tnh_status_t stat_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i,
  input  logic [9:0]  entry_node_i,
  input  logic [9:0]  entry_parent_i,
  input  logic [9:0]  entry_depth_i,
  input  logic [9:0]  source_node_i,
  input  logic [9:0]  dest_node_i,
  output logic [9:0]  next_hop_o
);

  node_t  node_count_q;
  node_t  s_q, s_d, d_q, d_d, u_q, u_d, v_q, v_d, pu_q, pu_d, l_q, l_d;
  node_t  next_hop_q, next_hop_d;
  depth_t ds_q, ds_d, dd_q, dd_d;
  depth_t diff;
  step_t  step_q, step_d;

  node_t  tbl_raddr, tbl_waddr, tbl_wdata, tbl_rdata;
  node_t  tbl_rdata_lvl [LIFT_LEVELS];
  logic [LIFT_LEVELS-1:0] tbl_we;
  node_t  dep_raddr;
  depth_t dep_rdata;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= node_t'(1);
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // ancestor table write side
  always_comb begin
    tbl_waddr = cmd_i.node;
    tbl_wdata = tbl_rdata;
    tbl_we    = '0;
    unique case (cmd_i.wr_mode)
      WR_CLEAR: begin
        tbl_we    = '1;
        tbl_wdata = '0;
      end
      WR_LOAD: begin
        tbl_we[0] = 1'b1;
        tbl_waddr = entry_node_i;
        tbl_wdata = entry_parent_i;
      end
      WR_BUILD: begin
        // reading level k-1, writing level k
        for (int g = 1; g < LIFT_LEVELS; g++) begin
          tbl_we[g] = (cmd_i.level == level_t'(g - 1));
        end
      end
      default: begin
        tbl_we = '0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_NODE: tbl_raddr = cmd_i.node;
      RD_TBL:  tbl_raddr = tbl_rdata;
      RD_U:    tbl_raddr = u_q;
      RD_V:    tbl_raddr = v_q;
      default: tbl_raddr = u_q;
    endcase
  end

  for (genvar g = 0; g < LIFT_LEVELS; g++) begin : g_level
    tnh_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
    ) u_tbl_ram (
      .clk_i   (clk_i),
      .we_i    (tbl_we[g]),
      .waddr_i (tbl_waddr),
      .wdata_i (tbl_wdata),
      .raddr_i (tbl_raddr),
      .rdata_o (tbl_rdata_lvl[g])
    );
  end

  assign tbl_rdata = tbl_rdata_lvl[cmd_i.level];

  assign dep_raddr = (cmd_i.dep_sel == DEP_S) ? s_q : d_q;

  tnh_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_NODES)
  ) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_mode == WR_LOAD),
    .waddr_i (entry_node_i),
    .wdata_i (entry_depth_i),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  // query working registers
  always_comb begin
    s_d        = s_q;
    d_d        = d_q;
    u_d        = u_q;
    v_d        = v_q;
    pu_d       = pu_q;
    l_d        = l_q;
    ds_d       = ds_q;
    dd_d       = dd_q;
    step_d     = step_q;
    next_hop_d = next_hop_q;
    diff       = '0;
    unique case (cmd_i.op)
      DP_ACCEPT: begin
        s_d = source_node_i;
        d_d = dest_node_i;
      end
      DP_CAP_DS: ds_d = dep_rdata;
      DP_SETUP: begin
        dd_d = dep_rdata;
        // the deeper node is lifted first
        if (ds_q < dep_rdata) begin
          u_d  = d_q;
          v_d  = s_q;
          diff = dep_rdata - ds_q;
        end else begin
          u_d  = s_q;
          v_d  = d_q;
          diff = ds_q - dep_rdata;
        end
        step_d = diff[LIFT_LEVELS-1:0];
      end
      DP_U_FROM_TBL: u_d = tbl_rdata;
      DP_L_FROM_U:   l_d = u_q;
      DP_CAP_PU:     pu_d = tbl_rdata;
      DP_JUMP: begin
        if (pu_q != tbl_rdata) begin
          u_d = pu_q;
          v_d = tbl_rdata;
        end
      end
      DP_L_FROM_TBL: l_d = tbl_rdata;
      DP_LIFT_D: begin
        u_d    = d_q;
        diff   = dd_q - ds_q - depth_t'(1);
        step_d = diff[LIFT_LEVELS-1:0];
      end
      DP_LIFT_S: begin
        u_d    = s_q;
        step_d = step_t'(1);
      end
      DP_RES_U:    next_hop_d = u_q;
      DP_RES_ZERO: next_hop_d = '0;
      default: begin
        diff = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    d_q        <= d_d;
    u_q        <= u_d;
    v_q        <= v_d;
    pu_q       <= pu_d;
    l_q        <= l_d;
    ds_q       <= ds_d;
    dd_q       <= dd_d;
    step_q     <= step_d;
    next_hop_q <= next_hop_d;
  end

  assign next_hop_o = next_hop_q;

  assign stat_o.step       = step_q;
  assign stat_o.node_count = node_count_q;
  assign stat_o.u_zero     = (u_q == '0);
  assign stat_o.u_eq_v     = (u_q == v_q);
  assign stat_o.l_eq_s     = (l_q == s_q);
  assign stat_o.dd_le_ds   = (dd_q <= ds_q);

endmodule

// File: rtl/core/tnh_controller.sv
// tnh_controller: state machine sequencing table clear, build and query steps,
// plus the busy flag and the result strobe.
// Depends on tnh_pkg.
module tnh_controller import tnh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  operation_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output tnh_cmd_t    cmd_o,
  input  tnh_status_t stat_i
);

  state_e state_q, state_d;
  level_t k_q, k_d;
  node_t  cnt_q, cnt_d;
  logic   final_q, final_d;
  logic   valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      k_q     <= '0;
      cnt_q   <= '0;
      final_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      final_q <= final_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    final_d = final_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + node_t'(1);
        if (cnt_q == node_t'(MAX_NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_e'(operation_i))
            OP_BUILD: begin
              if (stat_i.node_count != '0) begin
                state_d = ST_B_RD1;
                k_d     = '0;
                cnt_d   = node_t'(1);
              end
            end
            OP_QUERY: state_d = ST_Q_DS;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_B_RD1: state_d = ST_B_RD2;
      ST_B_RD2: state_d = ST_B_WR;
      ST_B_WR: begin
        state_d = ST_B_RD1;
        if (cnt_q == stat_i.node_count) begin
          cnt_d = node_t'(1);
          if (k_q == level_t'(LIFT_LEVELS - 2)) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + level_t'(1);
          end
        end else begin
          cnt_d = cnt_q + node_t'(1);
        end
      end
      ST_Q_DS: state_d = ST_Q_DD;
      ST_Q_DD: state_d = ST_Q_SETUP;
      ST_Q_SETUP: begin
        state_d = ST_LIFT_CHK;
        k_d     = level_t'(LIFT_LEVELS - 1);
        final_d = 1'b0;
      end
      ST_LIFT_CHK: begin
        // the final lift stops once it reaches node zero
        priority if (final_q && stat_i.u_zero) begin
          state_d = ST_RESULT;
        end else if (stat_i.step[k_q]) begin
          state_d = ST_LIFT_WT;
        end else if (k_q == '0) begin
          state_d = final_q ? ST_RESULT : ST_CMP;
        end else begin
          k_d = k_q - level_t'(1);
        end
      end
      ST_LIFT_WT: begin
        if (k_q == '0) begin
          state_d = final_q ? ST_RESULT : ST_CMP;
        end else begin
          k_d     = k_q - level_t'(1);
          state_d = ST_LIFT_CHK;
        end
      end
      ST_CMP: begin
        if (stat_i.u_eq_v) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_J_RU;
          k_d     = level_t'(LIFT_LEVELS - 1);
        end
      end
      ST_J_RU: state_d = ST_J_RV;
      ST_J_RV: state_d = ST_J_CMP;
      ST_J_CMP: begin
        if (k_q == '0) begin
          state_d = ST_PAR_RD;
        end else begin
          k_d     = k_q - level_t'(1);
          state_d = ST_J_RU;
        end
      end
      ST_PAR_RD: state_d = ST_PAR_WT;
      ST_PAR_WT: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (stat_i.l_eq_s && stat_i.dd_le_ds) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LIFT_CHK;
          k_d     = level_t'(LIFT_LEVELS - 1);
          final_d = 1'b1;
        end
      end
      ST_RESULT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op      = DP_NOP;
    cmd_o.wr_mode = WR_NONE;
    cmd_o.rd_sel  = RD_U;
    cmd_o.dep_sel = DEP_S;
    cmd_o.node    = cnt_q;
    cmd_o.level   = k_q;
    unique case (state_q)
      ST_CLEAR: cmd_o.wr_mode = WR_CLEAR;
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_e'(operation_i))
            OP_LOAD:  cmd_o.wr_mode = WR_LOAD;
            OP_QUERY: cmd_o.op = DP_ACCEPT;
            default:  cmd_o.op = DP_NOP;
          endcase
        end
      end
      ST_B_RD1: cmd_o.rd_sel = RD_NODE;
      ST_B_RD2: cmd_o.rd_sel = RD_TBL;
      ST_B_WR:  cmd_o.wr_mode = WR_BUILD;
      ST_Q_DS:  cmd_o.dep_sel = DEP_S;
      ST_Q_DD: begin
        cmd_o.op      = DP_CAP_DS;
        cmd_o.dep_sel = DEP_D;
      end
      ST_Q_SETUP:  cmd_o.op = DP_SETUP;
      ST_LIFT_CHK: cmd_o.rd_sel = RD_U;
      ST_LIFT_WT:  cmd_o.op = DP_U_FROM_TBL;
      ST_CMP: begin
        if (stat_i.u_eq_v) begin
          cmd_o.op = DP_L_FROM_U;
        end
      end
      ST_J_RU: cmd_o.rd_sel = RD_U;
      ST_J_RV: begin
        cmd_o.op     = DP_CAP_PU;
        cmd_o.rd_sel = RD_V;
      end
      ST_J_CMP: cmd_o.op = DP_JUMP;
      ST_PAR_RD: cmd_o.level = '0;
      ST_PAR_WT: begin
        cmd_o.op    = DP_L_FROM_TBL;
        cmd_o.level = '0;
      end
      ST_DECIDE: begin
        priority if (stat_i.l_eq_s && stat_i.dd_le_ds) begin
          cmd_o.op = DP_RES_ZERO;
        end else if (stat_i.l_eq_s) begin
          cmd_o.op = DP_LIFT_D;
        end else begin
          cmd_o.op = DP_LIFT_S;
        end
      end
      ST_RESULT: cmd_o.op = DP_RES_U;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  assign valid_d = (cmd_o.op == DP_RES_U) || (cmd_o.op == DP_RES_ZERO);

endmodule

// File: rtl/core/tnh_checker.sv
// tnh_checker: port-level assertions for tree_next_hop_binary_lifting,
// attached to the top level by the bind below. Depends on tnh_pkg.
module tnh_checker import tnh_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] operation_i,
  input logic       result_valid_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // a query passes through the depth reads and the lift before its result, so strobes never touch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // the controller is back in idle when the result shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result shown while busy");

  // an accepted query occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == OP_QUERY) |=> busy_o)
    else $error("query accepted without going busy");

  // a load completes in its accept cycle and gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == OP_LOAD) |=> (!busy_o && !result_valid_o))
    else $error("load item disturbed busy or result");

endmodule

bind tree_next_hop_binary_lifting tnh_checker u_checker (.*);

// File: bench/tnh_hop_checker.sv
// tnh_hop_checker: watches the item, result and config channels of the tree next-hop
// unit, predicts each query's next hop and compares it with the block's result.
// Depends on tnh_pkg for widths and operation codes.
module tnh_hop_checker
  import tnh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  operation_i,
  input  node_t       entry_node_i,
  input  node_t       entry_parent_i,
  input  depth_t      entry_depth_i,
  input  node_t       source_node_i,
  input  node_t       dest_node_i,
  input  logic        result_valid_i,
  input  node_t       next_hop_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  node_t       cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // level k of a row holds the 2^k-th ancestor
  node_t       hop_tbl [MAX_NODES][LIFT_LEVELS];
  depth_t      hop_depth [MAX_NODES];
  node_t       span_reg;
  node_t       hop_q [$];
  int unsigned bad_cnt;
  node_t       want;

  function automatic node_t climb(node_t u, step_t steps);
    for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
      if (u == '0) break;
      if (steps[i]) u = hop_tbl[u][i];
    end
    return u;
  endfunction

  function automatic node_t meet(node_t u, node_t v);
    node_t  t;
    node_t  pu;
    node_t  pv;
    depth_t gap;
    if (hop_depth[u] < hop_depth[v]) begin
      t = u;
      u = v;
      v = t;
    end
    // the gap is taken again after every jump, from the node reached
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      gap = hop_depth[u] - hop_depth[v];
      if (gap[k]) u = hop_tbl[u][k];
    end
    if (u == v) return u;
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      pu = hop_tbl[u][k];
      pv = hop_tbl[v][k];
      if (pu != pv) begin
        u = pu;
        v = pv;
      end
    end
    return hop_tbl[u][0];
  endfunction

  function automatic node_t next_hop_of(node_t s, node_t d);
    node_t  l;
    depth_t ds;
    depth_t dd;
    l  = meet(s, d);
    ds = hop_depth[s];
    dd = hop_depth[d];
    if (l == s) begin
      if (dd <= ds) return '0;
      return climb(d, step_t'(dd - ds - 1'b1));
    end
    return climb(s, step_t'(1));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < MAX_NODES; u++) begin
        hop_depth[u] = '0;
        for (int k = 0; k < LIFT_LEVELS; k++) hop_tbl[u][k] = '0;
      end
      span_reg = node_t'(1);
      hop_q.delete();
      bad_cnt = 0;
      pending_o <= 0;
      fails_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (hop_q.size() == 0) begin
          bad_cnt++;
          $display("%0t: next_hop expected none, actual %0d", $time, next_hop_i);
        end else begin
          want = hop_q.pop_front();
          if (want !== next_hop_i) begin
            bad_cnt++;
            $display("%0t: next_hop expected %0d, actual %0d", $time, want, next_hop_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) span_reg = cfg_data_i;
      if (start_i && !busy_i) begin
        case (operation_i)
          OP_LOAD: begin
            hop_tbl[entry_node_i][0] = entry_parent_i;
            hop_depth[entry_node_i] = entry_depth_i;
          end
          OP_BUILD: begin
            // level 0 stays as loaded
            for (int k = 1; k < LIFT_LEVELS; k++)
              for (int u = 1; u <= span_reg; u++)
                hop_tbl[u][k] = hop_tbl[hop_tbl[u][k-1]][k-1];
          end
          OP_QUERY: hop_q.push_back(next_hop_of(source_node_i, dest_node_i));
          default: ;
        endcase
      end
      pending_o <= hop_q.size();
      fails_o <= bad_cnt;
    end
  end

endmodule

// File: bench/testbench.sv
// testbench: drives load, build and query items into the tree next-hop unit and
// gives the verdict; prediction and comparison live in tnh_hop_checker.
// Depends on tnh_pkg, tree_next_hop_binary_lifting and tnh_hop_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tnh_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int TOTAL_ITEMS  = 1350;
  localparam int CALM_ITEMS   = 150;
  localparam int BUILD_CYCLES = 27;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  operation_i;
  node_t       entry_node_i;
  node_t       entry_parent_i;
  depth_t      entry_depth_i;
  node_t       source_node_i;
  node_t       dest_node_i;
  logic        result_valid_o;
  node_t       next_hop_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  node_t       cfg_data_i;
  int unsigned pending;
  int unsigned fails;

  bit          seen [MAX_NODES];
  node_t       seen_list [$];
  int          items_sent;
  node_t       cur_cnt;

  tree_next_hop_binary_lifting u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .entry_node_i   (entry_node_i),
    .entry_parent_i (entry_parent_i),
    .entry_depth_i  (entry_depth_i),
    .source_node_i  (source_node_i),
    .dest_node_i    (dest_node_i),
    .result_valid_o (result_valid_o),
    .next_hop_o     (next_hop_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  tnh_hop_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .operation_i    (operation_i),
    .entry_node_i   (entry_node_i),
    .entry_parent_i (entry_parent_i),
    .entry_depth_i  (entry_depth_i),
    .source_node_i  (source_node_i),
    .dest_node_i    (dest_node_i),
    .result_valid_i (result_valid_o),
    .next_hop_i     (next_hop_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .fails_o        (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tree_next_hop_binary_lifting: mismatch");
    $finish;
  end

  function automatic node_t any_node();
    return node_t'($urandom_range(0, MAX_NODES - 1));
  endfunction

  // only nodes with a loaded depth may be walked to
  function automatic node_t seen_pick();
    return seen_list[$urandom_range(0, seen_list.size() - 1)];
  endfunction

  task automatic send_item(input logic [1:0] op, input node_t en, input node_t ep,
                           input depth_t ed, input node_t s, input node_t d);
    if (items_sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    entry_node_i   <= en;
    entry_parent_i <= ep;
    entry_depth_i  <= ed;
    source_node_i  <= s;
    dest_node_i    <= d;
    do @(posedge clk_i); while (busy_o);
    if (op == OP_LOAD && !seen[en]) begin
      seen[en] = 1'b1;
      seen_list.push_back(en);
    end
    items_sent++;
  endtask

  task automatic load_node(input node_t n, input node_t p, input depth_t dep);
    send_item(OP_LOAD, n, p, dep, any_node(), any_node());
  endtask

  task automatic ask_hop(input node_t s, input node_t d);
    send_item(OP_QUERY, any_node(), any_node(), depth_t'(any_node()), s, d);
  endtask

  task automatic build_item();
    send_item(OP_BUILD, any_node(), any_node(), depth_t'(any_node()), any_node(), any_node());
  endtask

  task automatic spare_item();
    send_item(OP_SPARE, any_node(), any_node(), depth_t'(any_node()), any_node(), any_node());
  endtask

  // stop sending, drain the outstanding hops, then let a running build finish
  task automatic settle(input int extra);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_count(input node_t n);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_cnt = n;
  endtask

  // loads a well-formed tree on n distinct labels in 1..cnt, builds if asked, queries it
  task automatic tree_phase(input int n, input node_t cnt, input bit chain,
                            input bit skip_build, input int queries);
    node_t  lab [$];
    int     up [$];
    depth_t lvl [$];
    bit     used [MAX_NODES];
    node_t  cand;
    int     pick;
    int     j;
    int     hops;
    int     r;
    settle(BUILD_CYCLES * cur_cnt + 64);
    set_count(cnt);
    while (lab.size() < n) begin
      cand = node_t'($urandom_range(1, cnt));
      if (!used[cand]) begin
        used[cand] = 1'b1;
        lab.push_back(cand);
      end
    end
    for (int i = 0; i < n; i++) begin
      pick = (i == 0) ? 0 : (chain ? i - 1 : $urandom_range(0, i - 1));
      up.push_back(pick);
      lvl.push_back(i == 0 ? depth_t'(0) : depth_t'(lvl[pick] + 1));
      load_node(lab[i], lab[pick], lvl[i]);
      if ($urandom_range(0, 15) == 0) spare_item();
    end
    if (!skip_build) build_item();
    for (int q = 0; q < queries; q++) begin
      r = $urandom_range(0, 19);
      j = $urandom_range(0, n - 1);
      case (r)
        0: load_node(any_node(), seen_pick(), depth_t'($urandom_range(0, MAX_NODES - 1)));
        1: spare_item();
        2: ask_hop(seen_pick(), seen_pick());
        3: settle(0);
        4, 5: ask_hop(lab[j], lab[j]);
        6, 7, 8, 9: begin
          // pair a node with one of its ancestors, in either order
          pick = j;
          hops = $urandom_range(0, lvl[j]);
          repeat (hops) pick = up[pick];
          if (r < 8) ask_hop(lab[pick], lab[j]);
          else ask_hop(lab[j], lab[pick]);
        end
        default: ask_hop(lab[j], lab[$urandom_range(0, n - 1)]);
      endcase
    end
  endtask

  initial begin
    int phase;
    int n;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    operation_i    <= OP_LOAD;
    entry_node_i   <= '0;
    entry_parent_i <= '0;
    entry_depth_i  <= '0;
    source_node_i  <= '0;
    dest_node_i    <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    items_sent = 0;
    cur_cnt = node_t'(1);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small hand-made tree: 1 is the root, 2 and 4 its children, 3 under 2
    set_count(node_t'(4));
    load_node(node_t'(0), node_t'(0), depth_t'(0));
    load_node(node_t'(1), node_t'(1), depth_t'(0));
    load_node(node_t'(2), node_t'(1), depth_t'(1));
    load_node(node_t'(3), node_t'(2), depth_t'(2));
    load_node(node_t'(4), node_t'(1), depth_t'(1));
    ask_hop(node_t'(3), node_t'(1));
    build_item();
    ask_hop(node_t'(1), node_t'(3));
    ask_hop(node_t'(3), node_t'(3));
    ask_hop(node_t'(3), node_t'(4));
    ask_hop(node_t'(2), node_t'(1));
    ask_hop(node_t'(4), node_t'(2));
    send_item(OP_SPARE, '1, '1, '1, '1, '1);
    // highest node, outside the build range, deepest depth
    load_node(node_t'(1023), node_t'(1023), depth_t'(1023));
    ask_hop(node_t'(1023), node_t'(1023));
    ask_hop(node_t'(1023), node_t'(1));
    ask_hop(node_t'(1), node_t'(1023));
    ask_hop(node_t'(0), node_t'(0));
    ask_hop(node_t'(1), node_t'(0));
    // node zero given a real parent
    load_node(node_t'(0), node_t'(2), depth_t'(5));
    ask_hop(node_t'(0), node_t'(3));
    ask_hop(node_t'(4), node_t'(0));

    // one long chain so the deep lift levels get used, then a sparse wide tree
    tree_phase(530, node_t'(1023), 1'b1, 1'b0, 40);
    tree_phase(20, node_t'(1023), 1'b0, 1'b0, 30);
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 9) == 0) begin
        tree_phase(1, node_t'(1), 1'b0, 1'b0, $urandom_range(4, 10));
      end else begin
        n = $urandom_range(2, 24);
        tree_phase(n, node_t'(n + $urandom_range(0, 4)), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 11) == 0, $urandom_range(8, 30));
      end
      phase++;
    end

    settle(BUILD_CYCLES * cur_cnt + 200);
    if (fails == 0 && pending == 0) begin
      $display("tree_next_hop_binary_lifting: match");
    end else begin
      $display("tree_next_hop_binary_lifting: mismatch");
    end
    $finish;
  end

endmodule
